### hdl/icu_pkg.sv
// ----------------------------------------------------------------------------
// icu_pkg: shared constants for the integer calculator unit
// Operation codes, status codes and the default data width.
// ----------------------------------------------------------------------------
package icu_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int IO_W = 32;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_SQR  = 4'd4;
    localparam logic [3:0] OP_POW  = 4'd5;
    localparam logic [3:0] OP_PRIME = 4'd6;
    localparam logic [3:0] OP_MAX  = 4'd7;
    localparam logic [3:0] OP_MIN  = 4'd8;
    localparam logic [3:0] OP_FACT = 4'd9;
    localparam logic [3:0] OP_MOD  = 4'd10;
    localparam logic [3:0] OP_SQRT = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_NEGSQ = 2'd2;
endpackage

### hdl/icu_div.sv
// ----------------------------------------------------------------------------
// icu_div: shared unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icu_div #(
    parameter int W = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] r_quo, r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [W:0] w_try;
    logic [W:0] w_sh;

    assign w_sh  = {r_rem, r_quo[W-1]};
    assign w_try = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_try[W]) begin
                    r_rem <= w_try[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

### hdl/icu_seq.sv
// ----------------------------------------------------------------------------
// icu_seq: operation sequencer
// Steps each operation through its states, using one shared multiplier and the divider.
// ----------------------------------------------------------------------------
module icu_seq #(
    parameter int W = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  logic [3:0] i_func,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic o_busy,
    output logic o_done,
    output logic [W-1:0] o_res,
    output logic [1:0] o_st
);
    import icu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;   // power / factorial / square / mul
    localparam logic [2:0] S_DIVW = 3'd2;   // waiting on divider
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_PRM  = 3'd4;   // prime: check d*d, launch trial divide
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_PRMW = 3'd6;   // prime: trial divide in flight
    localparam int SW = (W + 1) / 2;

    logic [2:0] r_state;
    logic [3:0] r_func;
    logic [W-1:0] r_a, r_acc, r_base, r_e, r_res, r_x;
    logic [W-1:0] r_root, r_bit, r_d;
    logic [1:0] r_st;
    logic r_phase, r_na, r_nb, r_done;

    logic [W-1:0] w_mx, w_my, w_prod;
    logic [2*W-1:0] w_full;
    logic w_dstart;
    logic [W-1:0] w_dnum, w_dden, w_quo, w_rem;
    logic w_ddone;
    logic [W-1:0] w_ma, w_mb, w_rb;
    logic w_lt;
    logic w_sq_gt;

    assign w_ma = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_lt = $signed(i_a) < $signed(i_b);
    assign w_rb = r_root + r_bit;

    // the one shared multiplier
    assign w_full = w_mx * w_my;
    assign w_prod = w_full[W-1:0];
    assign w_sq_gt = w_full > (2*W)'(r_x);

    always_comb begin
        w_mx = r_acc;
        w_my = r_base;
        if (r_func == OP_POW && r_phase) begin
            w_mx = r_base;
        end else if (r_func == OP_FACT) begin
            w_my = r_e;
        end else if (r_state == S_PRM) begin
            w_mx = r_d;
            w_my = r_d;
        end
    end

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = r_x;
        w_dden   = r_d;
        if (i_go && (i_func == OP_DIV || i_func == OP_MOD) && i_b != '0) begin
            w_dstart = 1'b1;
            w_dnum   = w_ma;
            w_dden   = w_mb;
        end else if (r_state == S_PRM && !w_sq_gt) begin
            w_dstart = 1'b1;
        end
    end

    icu_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_go) begin
                    r_func <= i_func;
                    r_a <= i_a;
                    r_na <= i_a[W-1]; r_nb <= i_b[W-1];
                    r_st <= ST_OK;
                    r_res <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_OUT;
                    case (i_func)
                        OP_ADD: r_res <= i_a + i_b;
                        OP_SUB: r_res <= i_a - i_b;
                        OP_MAX: r_res <= w_lt ? i_b : i_a;
                        OP_MIN: r_res <= w_lt ? i_a : i_b;
                        OP_MUL: begin
                            r_acc <= i_a; r_base <= i_b; r_state <= S_RUN;
                        end
                        OP_SQR: begin
                            r_acc <= i_a; r_base <= i_a; r_state <= S_RUN;
                        end
                        OP_DIV, OP_MOD: begin
                            if (i_b == '0) r_st <= ST_DIV0;
                            else r_state <= S_DIVW;
                        end
                        OP_POW: begin
                            if (!i_b[W-1]) begin
                                r_acc <= W'(1); r_base <= i_a; r_e <= i_b;
                                r_state <= S_RUN;
                            end else if (i_a == '0) begin
                                r_st <= ST_DIV0;
                            end else if (i_a == W'(1)) begin
                                r_res <= W'(1);
                            end else if (i_a == '1) begin
                                r_res <= i_b[0] ? '1 : W'(1);
                            end
                        end
                        OP_FACT: begin
                            if (i_a[W-1]) r_res <= '1;
                            else begin
                                r_acc <= W'(1); r_e <= W'(2); r_state <= S_RUN;
                            end
                        end
                        OP_PRIME: begin
                            if (i_a[W-1]) r_res <= '1;
                            else if (i_a < W'(2)) r_res <= '0;
                            else begin
                                r_x <= i_a; r_d <= W'(2); r_state <= S_PRM;
                            end
                        end
                        OP_SQRT: begin
                            if (i_a[W-1]) r_st <= ST_NEGSQ;
                            else begin
                                r_x <= i_a; r_root <= '0;
                                r_bit <= W'(1) << (2 * (SW - 1));
                                r_state <= S_SQRT;
                            end
                        end
                        default: r_res <= '0;
                    endcase
                end
                S_RUN: begin
                    case (r_func)
                        OP_MUL, OP_SQR: begin
                            r_res <= w_prod; r_state <= S_OUT;
                        end
                        OP_POW: begin
                            // alternate: multiply acc, then square base
                            if (r_e == '0) begin
                                r_res <= r_acc; r_state <= S_OUT;
                            end else if (!r_phase) begin
                                if (r_e[0]) r_acc <= w_prod;
                                r_phase <= 1'b1;
                            end else begin
                                r_base <= w_prod;
                                r_e <= r_e >> 1;
                                r_phase <= 1'b0;
                            end
                        end
                        default: begin
                            if (r_e > r_a || r_acc == '0) begin
                                r_res <= r_acc; r_state <= S_OUT;
                            end else begin
                                r_acc <= w_prod;
                                r_e <= r_e + 1'b1;
                            end
                        end
                    endcase
                end
                S_DIVW: if (w_ddone) begin
                    if (r_func == OP_DIV)
                        r_res <= (r_na != r_nb) ? (~w_quo + 1'b1) : w_quo;
                    else
                        r_res <= r_na ? (~w_rem + 1'b1) : w_rem;
                    r_state <= S_OUT;
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_res <= r_root; r_state <= S_OUT;
                    end else begin
                        if (r_x >= w_rb) begin
                            r_x <= r_x - w_rb;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_PRM: begin
                    // d*d past n means no divisor left; otherwise n / d is launched
                    if (w_sq_gt) begin
                        r_res <= W'(1); r_state <= S_OUT;
                    end else begin
                        r_state <= S_PRMW;
                    end
                end
                S_PRMW: if (w_ddone) begin
                    if (w_rem == '0) begin
                        r_res <= '0; r_state <= S_OUT;
                    end else begin
                        r_d <= r_d + 1'b1;
                        r_state <= S_PRM;
                    end
                end
                S_OUT: begin
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_st   = r_st;
endmodule

### hdl/integer_calculator_unit.sv
// ----------------------------------------------------------------------------
// integer_calculator_unit: iterative 32-bit signed integer calculator
// Add/sub/max/min are settled on acceptance; mul/square use the multiplier once,
// div/mod wait for the divider, power multiplies and squares per exponent bit, sqrt
// runs bit by bit, factorial stops at a or once the product wraps to 0, and prime
// tries each divisor up to sqrt(n); zero divisor and other early outs go straight out.
// One item at a time: busy holds through the result beat, so a new start waits for it.
// Synchronous reset idles the sequencer; the strobed result cannot be stalled.
// ----------------------------------------------------------------------------
module integer_calculator_unit #(
    parameter int DATA_WIDTH = icu_pkg::DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic [3:0] i_func,
    input  logic signed [icu_pkg::IO_W-1:0] i_operand_a,
    input  logic signed [icu_pkg::IO_W-1:0] i_operand_b,
    output logic o_valid,
    output logic signed [icu_pkg::IO_W-1:0] o_result,
    output logic [1:0] o_status
);
    import icu_pkg::*;

    logic [DATA_WIDTH-1:0] w_a, w_b, w_res;
    logic [IO_W-1:0] w_ext;
    logic [DATA_WIDTH+IO_W-1:0] w_rx;

    assign w_a = DATA_WIDTH'({{DATA_WIDTH{i_operand_a[IO_W-1]}}, i_operand_a});
    assign w_b = DATA_WIDTH'({{DATA_WIDTH{i_operand_b[IO_W-1]}}, i_operand_b});

    icu_seq #(.W(DATA_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start && !busy),
        .i_func(i_func), .i_a(w_a), .i_b(w_b),
        .o_busy(busy), .o_done(o_valid), .o_res(w_res), .o_st(o_status)
    );

    assign w_rx  = {{IO_W{w_res[DATA_WIDTH-1]}}, w_res};
    assign w_ext = w_rx[IO_W-1:0];
    assign o_result = w_ext;

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe while idle");
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result beat");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_DIV0 ||
                     o_status == ST_NEGSQ)) else $error("bad status");
endmodule
